// ===== design/lru_open_handle_tracker_top_assert.svh =====
// Assertion macros for the LRU open-handle tracker.
`ifndef LRU_OPEN_HANDLE_TRACKER_TOP_ASSERT_SVH
`define LRU_OPEN_HANDLE_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LOHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define LOHT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LOHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LOHT_ASSERT(label, prop, msg)
`define LOHT_ASSERT_IMPL(label, ante, cons, msg)
`define LOHT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/loht_pkg.sv =====
// Shared types and constants of the LRU open-handle tracker.
package loht_pkg;

   localparam int HANDLES  = 256;
   localparam int HANDLE_W = 8;
   localparam int LINK_W   = $clog2(HANDLES);
   localparam int COUNT_W  = 9;
   localparam int CAP_W    = 9;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(50);

   typedef enum logic [1:0] {
      REQ_USE   = 2'd0,
      REQ_OPEN  = 2'd1,
      REQ_CLOSE = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE         = 2'd0,
      ST_OPEN_FAILED  = 2'd1,
      ST_ALREADY_OPEN = 2'd2,
      ST_NOT_OPEN     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [HANDLE_W-1:0] handle;
      logic                open_ok;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                evicted_valid;
      logic [HANDLE_W-1:0] evicted_handle;
      logic                is_open;
      logic [COUNT_W-1:0]  open_count;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      logic       rd_tail;
      logic       mark_evict;
      logic       set_status;
      status_type status;
      logic       do_unlink;
      logic       do_link;
   } loht_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       open_ok;
      logic       in_range;
      logic       flag_open;
      logic       is_head;
      logic       need_evict;
   } loht_stat_type;

endpackage

// ===== design/loht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module loht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/loht_ctrl.sv =====
// Request sequencer of the LRU open-handle tracker.
`include "lru_open_handle_tracker_top_assert.svh"
module loht_ctrl import loht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  loht_stat_type stat,
   output loht_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_UNLINK,
      S_LINK,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      link_after_ff, link_after_in;
   logic      busy_ff, rsp_valid_ff;
   logic      accept;

   assign accept = start & ~busy_ff;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      link_after_in = link_after_ff;
      unique case (state_ff)
         S_IDLE, S_RESP: begin
            if (accept) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EVAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EVAL: begin
            cmd.set_status = 1'b1;
            state_in       = S_RESP;
            priority if (!stat.in_range) begin
               cmd.status = (stat.req_type == REQ_OPEN) ? ST_OPEN_FAILED : ST_NOT_OPEN;
            end else if (stat.req_type == REQ_OPEN) begin
               if (stat.flag_open) begin
                  cmd.status = ST_ALREADY_OPEN;
               end else begin
                  cmd.status    = stat.open_ok ? ST_DONE : ST_OPEN_FAILED;
                  link_after_in = stat.open_ok;
                  // evict the tail first, even when the open fails
                  if (stat.need_evict) begin
                     cmd.rd_en      = 1'b1;
                     cmd.rd_tail    = 1'b1;
                     cmd.mark_evict = 1'b1;
                     state_in       = S_UNLINK;
                  end else if (stat.open_ok) begin
                     state_in = S_LINK;
                  end
               end
            end else if (!stat.flag_open) begin
               cmd.status = ST_NOT_OPEN;
            end else begin
               cmd.status = ST_DONE;
               if (stat.req_type == REQ_USE && !stat.is_head) begin
                  cmd.rd_en     = 1'b1;
                  link_after_in = 1'b1;
                  state_in      = S_UNLINK;
               end else if (stat.req_type == REQ_CLOSE) begin
                  cmd.rd_en     = 1'b1;
                  link_after_in = 1'b0;
                  state_in      = S_UNLINK;
               end
            end
         end
         S_UNLINK: begin
            cmd.do_unlink = 1'b1;
            state_in      = link_after_ff ? S_LINK : S_RESP;
         end
         S_LINK: begin
            cmd.do_link = 1'b1;
            state_in    = S_RESP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         link_after_ff <= 1'b0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         link_after_ff <= link_after_in;
         busy_ff       <= (state_in != S_IDLE) && (state_in != S_RESP);
         rsp_valid_ff  <= (state_in == S_RESP);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   `LOHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `LOHT_ASSERT_NEXT(a_strobe_once, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `LOHT_ASSERT_NEXT(a_no_drop, busy, busy || rsp_valid, "request left work without a result")

endmodule

// ===== design/loht_dpath.sv =====
// Link memories, list pointers, open flags and result registers of the tracker.
`include "lru_open_handle_tracker_top_assert.svh"
module loht_dpath import loht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  req_item_type       req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_wdata,
   input  loht_cmd_type       cmd,
   output loht_stat_type      stat,
   output rsp_item_type       rsp_data
);

   req_item_type        req_ff;
   logic [CAP_W-1:0]    cap_ff;
   logic [LINK_W-1:0]   head_ff, head_in;
   logic [LINK_W-1:0]   tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [HANDLES-1:0]  flags_ff, flags_in;
   logic [LINK_W-1:0]   x_ff;
   status_type          status_ff;
   logic                ev_valid_ff;
   logic [LINK_W-1:0]   ev_handle_ff;

   logic [LINK_W-1:0]   hidx;
   logic                in_range;
   logic [COUNT_W-1:0]  cap_eff;
   logic [LINK_W-1:0]   rd_addr;
   logic [LINK_W-1:0]   nx, pv;
   logic                next_we, prev_we;
   logic [LINK_W-1:0]   next_wa, next_wd, prev_wa, prev_wd;

   assign csr_ready = 1'b1;
   assign hidx      = req_ff.handle[LINK_W-1:0];
   assign in_range  = (int'(req_ff.handle) < HANDLES);
   assign rd_addr   = cmd.rd_tail ? tail_ff : hidx;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = COUNT_W'(1);
      end else if (int'(cap_ff) > HANDLES) begin
         cap_eff = COUNT_W'(HANDLES);
      end else begin
         cap_eff = COUNT_W'(cap_ff);
      end
   end

   always_comb begin
      stat.req_type   = req_ff.req_type;
      stat.open_ok    = req_ff.open_ok;
      stat.in_range   = in_range;
      stat.flag_open  = flags_ff[hidx];
      stat.is_head    = (head_ff == hidx);
      stat.need_evict = (count_ff >= cap_eff) && (count_ff != '0);
   end

   loht_ram #(.WIDTH(LINK_W), .DEPTH(HANDLES)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (nx)
   );

   loht_ram #(.WIDTH(LINK_W), .DEPTH(HANDLES)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (pv)
   );

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      next_we  = 1'b0;
      next_wa  = pv;
      next_wd  = nx;
      prev_we  = 1'b0;
      prev_wa  = nx;
      prev_wd  = pv;
      if (cmd.do_unlink) begin
         // bridge the neighbors of x around it
         if (x_ff == head_ff) begin
            head_in = nx;
         end else begin
            next_we = 1'b1;
         end
         if (x_ff == tail_ff) begin
            tail_in = pv;
         end else begin
            prev_we = 1'b1;
         end
         if (count_ff != '0) begin
            count_in = count_ff - COUNT_W'(1);
         end
         flags_in[x_ff] = 1'b0;
      end else if (cmd.do_link) begin
         if (count_ff == '0) begin
            tail_in = hidx;
         end else begin
            next_we = 1'b1;
            next_wa = hidx;
            next_wd = head_ff;
            prev_we = 1'b1;
            prev_wa = head_ff;
            prev_wd = hidx;
         end
         head_in        = hidx;
         count_in       = count_ff + COUNT_W'(1);
         flags_in[hidx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         flags_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff       <= req_data;
         ev_valid_ff  <= 1'b0;
         ev_handle_ff <= '0;
      end
      if (cmd.rd_en) begin
         x_ff <= rd_addr;
      end
      if (cmd.mark_evict) begin
         ev_valid_ff  <= 1'b1;
         ev_handle_ff <= tail_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
   end

   always_comb begin
      rsp_data.status         = status_ff;
      rsp_data.evicted_valid  = ev_valid_ff;
      rsp_data.evicted_handle = HANDLE_W'(ev_handle_ff);
      rsp_data.is_open        = in_range & flags_ff[hidx];
      rsp_data.open_count     = count_ff;
   end

   `LOHT_ASSERT(a_count_flags, $countones(flags_ff) == int'(count_ff), "count and flags differ")
   `LOHT_ASSERT(a_count_max, int'(count_ff) <= HANDLES, "open count above handle total")
   `LOHT_ASSERT_IMPL(a_one_node, count_ff == COUNT_W'(1), head_ff == tail_ff, "list ends differ")

endmodule

// ===== design/lru_open_handle_tracker_top.sv =====
// Top level of the LRU open-handle tracker.
//
// Tracks which of 256 handle slots are open, most recent first, with a cap set
// through the csr_ write channel (csr_wdata is max_open, reset value 50; a cap
// of 0 acts as 1, above 256 as 256). csr_ready is always high.
// A request (use, open, close, query) is transferred at a clock edge with start
// high and busy low. Exactly one result follows on rsp_data, marked by rsp_valid
// for one cycle; the receiver must take it, there is no back-pressure.
// The result follows an evaluate state directly for query, failures without
// eviction and use of the front handle. An unlink or a link state comes between
// when the list is only unlinked or only linked (a failed open that evicts is
// only unlinked); unlink then link for a successful open with eviction or a use
// that moves a handle forward. busy is low in the result cycle, when a new
// request can be taken. Unlink uses the registered read of the link memories.
// Reset clears all open flags, the count and the list pointers and loads the
// cap; the link memories are not cleared and need no clearing pass.
module lru_open_handle_tracker_top import loht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_data,
   output logic             rsp_valid,
   output rsp_item_type     rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_wdata
);

   loht_cmd_type  cmd;
   loht_stat_type stat;

   loht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   loht_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the LRU open-handle tracker top level.
`timescale 1ns / 100ps

module testbench;
   import loht_pkg::*;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_item_type     req_data;
   logic             rsp_valid;
   rsp_item_type     rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_wdata;

   lru_open_handle_tracker_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the tracker: open flags, LRU links, head/tail and count.
   logic [CAP_W-1:0]    cap_setting = CAP_RESET;
   bit                  slot_open [HANDLES];
   bit [HANDLE_W-1:0]   link_next [HANDLES];
   bit [HANDLE_W-1:0]   link_prev [HANDLES];
   bit [HANDLE_W-1:0]   lru_head;
   bit [HANDLE_W-1:0]   lru_tail;
   int unsigned         n_open;

   rsp_item_type        pending_rsp [$];
   int unsigned         error_count;
   bit                  idle_en;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic void unlink_slot(input bit [HANDLE_W-1:0] h);
      bit [HANDLE_W-1:0] nx;
      bit [HANDLE_W-1:0] pv;
      nx = link_next[h];
      pv = link_prev[h];
      if (h == lru_head) lru_head = nx;
      else link_next[pv] = nx;
      if (h == lru_tail) lru_tail = pv;
      else link_prev[nx] = pv;
      if (n_open > 0) n_open--;
   endfunction

   function automatic void link_at_head(input bit [HANDLE_W-1:0] h);
      if (n_open == 0) begin
         lru_head = h;
         lru_tail = h;
      end else begin
         link_next[h] = lru_head;
         link_prev[lru_head] = h;
         lru_head = h;
      end
      n_open++;
   endfunction

   // Apply one request to the shadow state and return the result it must produce.
   function automatic rsp_item_type track_request(input req_item_type r);
      rsp_item_type      o;
      bit [HANDLE_W-1:0] h;
      bit [HANDLE_W-1:0] victim;
      int unsigned       limit;
      o = '0;
      h = r.handle;
      case (req_kind_type'(r.req_type))
         REQ_OPEN: begin
            if (slot_open[h]) begin
               o.status = ST_ALREADY_OPEN;
            end else begin
               limit = cap_setting;
               if (limit == 0) limit = 1;
               if (limit > HANDLES) limit = HANDLES;
               // evict before the open, even if the open then fails
               if (n_open >= limit && n_open > 0) begin
                  victim = lru_tail;
                  o.evicted_valid  = 1'b1;
                  o.evicted_handle = victim;
                  unlink_slot(victim);
                  slot_open[victim] = 1'b0;
               end
               if (r.open_ok) begin
                  link_at_head(h);
                  slot_open[h] = 1'b1;
                  o.status = ST_DONE;
               end else begin
                  o.status = ST_OPEN_FAILED;
               end
            end
         end
         default: begin
            if (!slot_open[h]) begin
               o.status = ST_NOT_OPEN;
            end else if (r.req_type == REQ_USE) begin
               if (lru_head != h) begin
                  unlink_slot(h);
                  link_at_head(h);
               end
            end else if (r.req_type == REQ_CLOSE) begin
               unlink_slot(h);
               slot_open[h] = 1'b0;
            end
            if (slot_open[h] || r.req_type != REQ_OPEN) begin
               o.status = slot_open[h] || r.req_type == REQ_CLOSE && o.status != ST_NOT_OPEN
                          ? ST_DONE : ST_NOT_OPEN;
            end
         end
      endcase
      o.is_open    = slot_open[h];
      o.open_count = (n_open > 511) ? 9'd511 : n_open[COUNT_W-1:0];
      return o;
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   function automatic void check_field(input string name, input logic [8:0] want,
                                       input logic [8:0] got);
      if (got !== want)
         flag_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
   endfunction

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            flag_error("result transfer with no request outstanding");
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 9'(want.status), 9'(rsp_data.status));
            check_field("evicted_valid", 9'(want.evicted_valid), 9'(rsp_data.evicted_valid));
            check_field("evicted_handle", 9'(want.evicted_handle),
                        9'(rsp_data.evicted_handle));
            check_field("is_open", 9'(want.is_open), 9'(rsp_data.is_open));
            check_field("open_count", want.open_count, rsp_data.open_count);
         end
      end
   end

   function automatic req_item_type make_req(input req_kind_type kind,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic ok);
      req_item_type r;
      r.req_type = kind;
      r.handle   = h;
      r.open_ok  = ok;
      return r;
   endfunction

   task automatic send_req(input req_item_type item);
      int gap;
      gap = idle_en ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(track_request(item));
   endtask

   // Drop start and wait until every outstanding result has come back.
   task automatic drain;
      @(negedge clock) start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_cap(input logic [CAP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cap_setting = value;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic req_item_type rand_req(input int unsigned open_w,
                                             input int unsigned close_w,
                                             input int unsigned pool_hi);
      int unsigned  roll;
      req_kind_type kind;
      roll = $urandom_range(0, 99);
      if (roll < open_w) kind = REQ_OPEN;
      else if (roll < open_w + close_w) kind = REQ_CLOSE;
      else if (roll[0]) kind = REQ_USE;
      else kind = REQ_QUERY;
      return make_req(kind, HANDLE_W'($urandom_range(0, pool_hi)),
                      $urandom_range(0, 9) != 0);
   endfunction

   // Requests against an empty tracker all report the handle as not open.
   task automatic test_idle_queries;
      send_req(make_req(REQ_QUERY, 8'h00, 1'b0));
      send_req(make_req(REQ_USE,   8'hFF, 1'b1));
      send_req(make_req(REQ_CLOSE, 8'h55, 1'b0));
   endtask

   task automatic test_open_use_close;
      send_req(make_req(REQ_OPEN,  8'h00, 1'b1));
      send_req(make_req(REQ_OPEN,  8'hFF, 1'b1));
      send_req(make_req(REQ_OPEN,  8'h00, 1'b1));   // already open
      send_req(make_req(REQ_USE,   8'hFF, 1'b0));   // front handle, order unchanged
      send_req(make_req(REQ_USE,   8'h00, 1'b0));
      send_req(make_req(REQ_OPEN,  8'hAA, 1'b0));   // backing open fails
      send_req(make_req(REQ_CLOSE, 8'hFF, 1'b0));
      send_req(make_req(REQ_QUERY, 8'h00, 1'b0));
      send_req(make_req(REQ_QUERY, 8'hFF, 1'b1));
   endtask

   task automatic test_eviction_small_cap;
      write_cap(9'd0);                              // acts as a cap of one
      send_req(make_req(REQ_OPEN, 8'h33, 1'b1));
      send_req(make_req(REQ_OPEN, 8'hCC, 1'b0));    // evicts even though it fails
      send_req(make_req(REQ_OPEN, 8'h0F, 1'b1));
      write_cap(9'd3);
      send_req(make_req(REQ_OPEN, 8'hF0, 1'b1));
      send_req(make_req(REQ_OPEN, 8'h01, 1'b1));
      // lower the cap under the count: each open evicts only one handle
      write_cap(9'd1);
      send_req(make_req(REQ_OPEN,  8'h80, 1'b1));
      send_req(make_req(REQ_USE,   8'h01, 1'b0));   // move from the middle
      send_req(make_req(REQ_CLOSE, 8'h80, 1'b0));
   endtask

   // Open every handle in shuffled order, then keep opening against a full list.
   task automatic test_full_table;
      logic [HANDLE_W-1:0] order [HANDLES];
      logic [HANDLE_W-1:0] tmp;
      int                  j;
      write_cap(9'd511);
      for (int i = 0; i < HANDLES; i++) order[i] = HANDLE_W'(i);
      for (int i = HANDLES - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < HANDLES; i++) begin
         if (i % 40 == 0) idle_en = $urandom_range(0, 3) != 0;
         send_req(make_req(REQ_OPEN, order[i], 1'b1));
      end
      for (int i = 0; i < 44; i++) send_req(rand_req(80, 0, 255));
   endtask

   task automatic test_random_mix(input logic [CAP_W-1:0] cap, input int n_items,
                                  input int unsigned open_w, input int unsigned close_w,
                                  input int unsigned pool_hi);
      write_cap(cap);
      for (int i = 0; i < n_items; i++) begin
         // alternate stretches with and without gaps
         if (i % 50 == 0) idle_en = $urandom_range(0, 3) != 0;
         send_req(rand_req(open_w, close_w, pool_hi));
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      idle_en   = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_idle_queries();
      test_open_use_close();
      test_eviction_small_cap();
      test_full_table();
      test_random_mix(9'd256, 300, 55, 15, 255);
      test_random_mix(CAP_RESET, 300, 45, 15, 255);
      for (int k = 0; k < 4; k++)
         test_random_mix(CAP_W'($urandom_range(1, 16)), 150, 45, 15, 31);
      test_random_mix(9'd0, 150, 50, 10, 7);
      test_random_mix(CAP_W'($urandom_range(0, 511)), 200, 50, 12, 63);

      drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
